/* rtl/core/jbeg_pkg.sv */
// ----------------------------------------------------------------------------
// jbeg_pkg
// Shared types, codes and timing constants of the joystick event generator.
// ----------------------------------------------------------------------------
package jbeg_pkg;

  localparam int SampleW = 12;
  localparam int TimeW   = 32;
  localparam int CodeW   = 3;
  localparam int IndexW  = 3;
  localparam int InDataW  = 64;
  localparam int OutDataW = 8;

  localparam logic [SampleW-1:0] SAMPLE_MAX = 12'd4095;

  localparam logic [TimeW-1:0] HOLD_MS         = 32'd600;
  localparam logic [TimeW-1:0] CLICK_MS        = 32'd35;
  localparam logic [TimeW-1:0] REPEAT_DELAY_MS = 32'd340;
  localparam logic [TimeW-1:0] REPEAT_GAP_MS   = 32'd110;
  localparam logic signed [14:0] DEAD_MIN      = 15'sd80;

  localparam logic [CodeW-1:0] EV_NONE  = 3'd0;
  localparam logic [CodeW-1:0] EV_OK    = 3'd1;
  localparam logic [CodeW-1:0] EV_EXIT  = 3'd2;
  localparam logic [CodeW-1:0] EV_UP    = 3'd3;
  localparam logic [CodeW-1:0] EV_DOWN  = 3'd4;
  localparam logic [CodeW-1:0] EV_LEFT  = 3'd5;
  localparam logic [CodeW-1:0] EV_TO_RIGHT = 3'd6;

  localparam logic [IndexW-1:0] REG_ROTATION = 3'd0;
  localparam logic [IndexW-1:0] REG_CENTER_X = 3'd1;
  localparam logic [IndexW-1:0] REG_CENTER_Y = 3'd2;
  localparam logic [IndexW-1:0] REG_LOW_X    = 3'd3;
  localparam logic [IndexW-1:0] REG_HIGH_X   = 3'd4;
  localparam logic [IndexW-1:0] REG_LOW_Y    = 3'd5;
  localparam logic [IndexW-1:0] REG_HIGH_Y   = 3'd6;

  // Classified poll handed from the front end to the event engine.
  typedef struct packed {
    logic [CodeW-1:0] dir;
    logic             sw;
    logic [TimeW-1:0] now;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* rtl/core/jbeg_front.sv */
// ----------------------------------------------------------------------------
// jbeg_front
// Holds the calibration registers, rotates the stick sample and turns it
// into a direction code.
// ----------------------------------------------------------------------------
module jbeg_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [jbeg_pkg::IndexW-1:0]  cfg_index,
  input  logic [jbeg_pkg::SampleW-1:0] cfg_wdata,
  input  logic [jbeg_pkg::SampleW-1:0] x_sample,
  input  logic [jbeg_pkg::SampleW-1:0] y_sample,
  input  logic                         button_pressed,
  input  logic [jbeg_pkg::TimeW-1:0]   now_ms,
  output jbeg_pkg::item_t              item
);
  import jbeg_pkg::*;

  localparam logic [1:0] AX_MID  = 2'd0;
  localparam logic [1:0] AX_LOW  = 2'd1;
  localparam logic [1:0] AX_HIGH = 2'd2;

  logic [1:0]         rotation_r;
  logic [SampleW-1:0] center_x_r, center_y_r, low_x_r, high_x_r, low_y_r, high_y_r;
  logic [SampleW-1:0] rx, ry;
  logic [1:0]         dx, dy;

  // Half distances are truncated toward zero, so a bound on the wrong side
  // of the center falls back to the minimum dead zone.
  function automatic logic [1:0] classify(input logic [SampleW-1:0] v,
                                          input logic [SampleW-1:0] c,
                                          input logic [SampleW-1:0] lo,
                                          input logic [SampleW-1:0] hi);
    logic signed [14:0] vs, cs, dl, dh, sl, sh, hl, hh, tl, tr;
    begin
      vs = signed'({3'b000, v});
      cs = signed'({3'b000, c});
      dl = cs - signed'({3'b000, lo});
      dh = signed'({3'b000, hi}) - cs;
      sl = dl + 15'(dl[14]);
      sh = dh + 15'(dh[14]);
      hl = sl >>> 1;
      hh = sh >>> 1;
      tl = (hl <= DEAD_MIN) ? (cs - DEAD_MIN) : (cs - hl);
      tr = (hh <= DEAD_MIN) ? (cs + DEAD_MIN) : (cs + hh);
      if (vs > tr) begin
        classify = AX_HIGH;
      end else if (vs < tl) begin
        classify = AX_LOW;
      end else begin
        classify = AX_MID;
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r <= 2'd0;
      center_x_r <= 12'd2048;
      center_y_r <= 12'd2048;
      low_x_r    <= 12'd1148;
      high_x_r   <= 12'd2948;
      low_y_r    <= 12'd1148;
      high_y_r   <= 12'd2948;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROTATION: rotation_r <= cfg_wdata[1:0];
        REG_CENTER_X: center_x_r <= cfg_wdata;
        REG_CENTER_Y: center_y_r <= cfg_wdata;
        REG_LOW_X:    low_x_r    <= cfg_wdata;
        REG_HIGH_X:   high_x_r   <= cfg_wdata;
        REG_LOW_Y:    low_y_r    <= cfg_wdata;
        REG_HIGH_Y:   high_y_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (rotation_r)
      2'd0: begin
        rx = x_sample;
        ry = y_sample;
      end
      2'd1: begin
        rx = y_sample;
        ry = SAMPLE_MAX - x_sample;
      end
      2'd2: begin
        rx = SAMPLE_MAX - x_sample;
        ry = SAMPLE_MAX - y_sample;
      end
      default: begin
        rx = SAMPLE_MAX - y_sample;
        ry = x_sample;
      end
    endcase
  end

  assign dx = classify(rx, center_x_r, low_x_r, high_x_r);
  assign dy = classify(ry, center_y_r, low_y_r, high_y_r);

  // Vertical wins over horizontal.
  always_comb begin
    if (dy == AX_LOW) begin
      item.dir = EV_UP;
    end else if (dy == AX_HIGH) begin
      item.dir = EV_DOWN;
    end else if (dx == AX_LOW) begin
      item.dir = EV_LEFT;
    end else if (dx == AX_HIGH) begin
      item.dir = EV_TO_RIGHT;
    end else begin
      item.dir = EV_NONE;
    end
    item.sw  = button_pressed;
    item.now = now_ms;
  end

endmodule

/* rtl/core/jbeg_queue.sv */
// ----------------------------------------------------------------------------
// jbeg_queue
// Two-entry queue of classified polls between the front end and the engine.
// ----------------------------------------------------------------------------
module jbeg_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  jbeg_pkg::item_t      push_item,
  input  logic                 pop,
  output jbeg_pkg::item_t      pop_item,
  output jbeg_pkg::q_status_t  status
);
  import jbeg_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item     = mem_r[rd_ptr_r];
  assign status.full  = count_r[1];
  assign status.empty = (count_r == 2'd0);

endmodule

/* rtl/core/jbeg_back.sv */
// ----------------------------------------------------------------------------
// jbeg_back
// Event engine: button hold and click timing, direction auto-repeat, and the
// output register of the result channel.
// ----------------------------------------------------------------------------
module jbeg_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_valid,
  input  jbeg_pkg::item_t            item,
  output logic                       item_pop,
  output logic                       ev_valid,
  output logic [jbeg_pkg::CodeW-1:0] ev_code,
  input  logic                       ev_ready
);
  import jbeg_pkg::*;

  logic             held_r, held_nxt;
  logic             exit_sent_r, exit_sent_nxt;
  logic [TimeW-1:0] press_time_r, press_time_nxt;
  logic [CodeW-1:0] last_dir_r, last_dir_nxt;
  logic [TimeW-1:0] dir_start_r, dir_start_nxt;
  logic [TimeW-1:0] repeat_r, repeat_nxt;
  logic             ev_valid_r, ev_valid_nxt;
  logic [CodeW-1:0] ev_code_r, ev_code_nxt;

  logic             press_edge, exit1, do_dir;
  logic [TimeW-1:0] press1, held_for;

  assign item_pop = item_valid && (!ev_valid_r || ev_ready);

  always_comb begin
    press_edge = item.sw && !held_r;
    press1     = press_edge ? item.now : press_time_r;
    exit1      = press_edge ? 1'b0 : exit_sent_r;
    held_for   = item.now - press1;

    held_nxt       = held_r;
    exit_sent_nxt  = exit_sent_r;
    press_time_nxt = press_time_r;
    last_dir_nxt   = last_dir_r;
    dir_start_nxt  = dir_start_r;
    repeat_nxt     = repeat_r;
    ev_code_nxt    = ev_code_r;
    ev_valid_nxt   = ev_valid_r && !ev_ready;
    do_dir         = 1'b0;

    if (item_pop) begin
      ev_valid_nxt   = 1'b1;
      ev_code_nxt    = EV_NONE;
      held_nxt       = held_r || item.sw;
      press_time_nxt = press1;
      exit_sent_nxt  = exit1;
      if (item.sw && !exit1 && (held_for >= HOLD_MS)) begin
        exit_sent_nxt = 1'b1;
        ev_code_nxt   = EV_EXIT;
      end else if (!item.sw && held_r) begin
        held_nxt       = 1'b0;
        press_time_nxt = '0;
        if (!exit1 && (held_for > CLICK_MS)) begin
          ev_code_nxt = EV_OK;
        end else begin
          do_dir = 1'b1;
        end
      end else begin
        do_dir = 1'b1;
      end

      // A poll that gave a button event leaves the direction state alone.
      if (do_dir) begin
        if (item.dir == EV_NONE) begin
          last_dir_nxt = EV_NONE;
        end else if (item.dir != last_dir_r) begin
          last_dir_nxt  = item.dir;
          dir_start_nxt = item.now;
          repeat_nxt    = item.now;
          ev_code_nxt   = item.dir;
        end else if (((item.now - dir_start_r) > REPEAT_DELAY_MS) &&
                     ((item.now - repeat_r) > REPEAT_GAP_MS)) begin
          repeat_nxt  = item.now;
          ev_code_nxt = item.dir;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= 1'b0;
      exit_sent_r  <= 1'b0;
      press_time_r <= '0;
      last_dir_r   <= EV_NONE;
      dir_start_r  <= '0;
      repeat_r     <= '0;
      ev_valid_r   <= 1'b0;
    end else begin
      held_r       <= held_nxt;
      exit_sent_r  <= exit_sent_nxt;
      press_time_r <= press_time_nxt;
      last_dir_r   <= last_dir_nxt;
      dir_start_r  <= dir_start_nxt;
      repeat_r     <= repeat_nxt;
      ev_valid_r   <= ev_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_code_r <= ev_code_nxt;
  end

  assign ev_valid = ev_valid_r;
  assign ev_code  = ev_code_r;

endmodule

/* rtl/core/joystick_button_event_generator_core.sv */
// ----------------------------------------------------------------------------
// joystick_button_event_generator_core
// Turns joystick and button polls into navigation events.
// ----------------------------------------------------------------------------
// Each input beat is one poll: stick X and Y samples, the button level and a
// millisecond timestamp. Every poll yields exactly one output beat carrying
// an event code (none, ok, exit, up, down, left, right).
// The calibration registers are written through the cfg_ port, one register
// per cycle with cfg_we high, and should only change while no poll is in
// flight.
// A poll is classified as it is accepted and written into a two-entry queue;
// the engine then pops it and registers its event when the output is free.
// Throughput is one poll per cycle while the receiver keeps up; the event
// engine handles one queued poll per cycle and sets that figure.
// When the receiver stalls, the event waits in the output register, the
// queue fills, and in_tready falls once both entries are taken.
// Reset (synchronous, rst_n low) restores the default calibration, clears
// the button and direction history and empties the queue and output.
// ----------------------------------------------------------------------------
module joystick_button_event_generator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [jbeg_pkg::IndexW-1:0]   cfg_index,
  input  logic [jbeg_pkg::SampleW-1:0]  cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [11:0] x_sample, [23:12] y_sample, [24] button_pressed, [56:25] now_ms
  input  logic [jbeg_pkg::InDataW-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [2:0] event_code
  output logic [jbeg_pkg::OutDataW-1:0] out_tdata
);
  import jbeg_pkg::*;

  item_t            front_item, q_item;
  q_status_t        q_st;
  logic             q_push, q_pop;
  logic [CodeW-1:0] ev_code;

  jbeg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .x_sample       (in_tdata[11:0]),
    .y_sample       (in_tdata[23:12]),
    .button_pressed (in_tdata[24]),
    .now_ms         (in_tdata[56:25]),
    .item           (front_item)
  );

  assign in_tready = !q_st.full;
  assign q_push    = in_tvalid && in_tready;

  jbeg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .pop       (q_pop),
    .pop_item  (q_item),
    .status    (q_st)
  );

  jbeg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (!q_st.empty),
    .item       (q_item),
    .item_pop   (q_pop),
    .ev_valid   (out_tvalid),
    .ev_code    (ev_code),
    .ev_ready   (out_tready)
  );

  assign out_tdata = {{(OutDataW - CodeW){1'b0}}, ev_code};

`ifndef SYNTH
  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_st.full && q_st.empty))
    else $error("queue reports full and empty at once");

  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_st.empty && (!out_tvalid || out_tready)) |=> out_tvalid)
    else $error("queued poll did not reach the output register");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] <= EV_TO_RIGHT))
    else $error("event code out of range");
`endif

endmodule
